>>> rtl/raf_pkg.sv
package raf_pkg;

    localparam int LIST_DEPTH  = 16;
    localparam int IDX_W       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int USED_W      = $clog2(LIST_DEPTH + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W   = 160;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 8;
    localparam int CFG_W       = 32;
    localparam int CNT_W       = 17;

    localparam logic [31:0] MAX_TIMEOUT_RST = 32'd60000000;
    localparam logic [15:0] RATE_LIMIT_RST  = 16'd60;
    localparam logic [23:0] WIN_LEN_RST     = 24'd60;

    typedef enum logic [1:0] {
        CFG_MAX_TIMEOUT = 2'd0,
        CFG_RATE_LIMIT  = 2'd1,
        CFG_WIN_LEN     = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_CHECK      = 2'd0,
        ACT_ADD_ACCEPT = 2'd1,
        ACT_ADD_REJECT = 2'd2,
        ACT_CLEAR      = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TIMEOUT = 3'd1,
        ST_DENIED  = 3'd2,
        ST_RATE    = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef struct packed {
        logic        needs_rate;
        t_status     status;
        logic [31:0] now_sec;
    } t_job;

endpackage

>>> rtl/raf_front.sv
module raf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  raf_pkg::t_action    i_action,
    input  logic [31:0]         i_host,
    input  logic [31:0]         i_timeout_us,
    input  logic [31:0]         i_now_sec,
    input  logic [31:0]         i_entry_net,
    input  logic [31:0]         i_entry_mask,
    input  logic [31:0]         i_max_timeout,
    output raf_pkg::t_job       o_job
);
    import raf_pkg::*;

    logic [31:0]       r_acc_net  [LIST_DEPTH];
    logic [31:0]       r_acc_mask [LIST_DEPTH];
    logic [31:0]       r_rej_net  [LIST_DEPTH];
    logic [31:0]       r_rej_mask [LIST_DEPTH];
    logic [USED_W-1:0] r_acc_used, n_acc_used;
    logic [USED_W-1:0] r_rej_used, n_rej_used;
    logic              w_acc_hit, w_rej_hit;
    logic              w_acc_full, w_rej_full;
    logic              w_acc_wr, w_rej_wr;

    assign w_acc_full = (r_acc_used >= USED_W'(LIST_DEPTH));
    assign w_rej_full = (r_rej_used >= USED_W'(LIST_DEPTH));

    always_comb begin
        w_acc_hit = 1'b0;
        w_rej_hit = 1'b0;
        for (int k = 0; k < LIST_DEPTH; k++) begin
            if ((USED_W'(k) < r_acc_used) && ((i_host & r_acc_mask[k]) == r_acc_net[k]))
                w_acc_hit = 1'b1;
            if ((USED_W'(k) < r_rej_used) && ((i_host & r_rej_mask[k]) == r_rej_net[k]))
                w_rej_hit = 1'b1;
        end
    end

    always_comb begin
        o_job.needs_rate = 1'b0;
        o_job.status     = ST_OK;
        o_job.now_sec    = i_now_sec;
        w_acc_wr         = 1'b0;
        w_rej_wr         = 1'b0;
        n_acc_used       = r_acc_used;
        n_rej_used       = r_rej_used;
        unique case (i_action)
            ACT_CHECK: begin
                if (i_timeout_us > i_max_timeout)
                    o_job.status = ST_TIMEOUT;
                else if ((r_acc_used != '0) && !w_acc_hit)
                    o_job.status = ST_DENIED;
                else if (w_rej_hit)
                    o_job.status = ST_DENIED;
                else
                    o_job.needs_rate = 1'b1;
            end
            ACT_ADD_ACCEPT: begin
                if (w_acc_full) begin
                    o_job.status = ST_FULL;
                end else begin
                    w_acc_wr   = i_fire;
                    n_acc_used = r_acc_used + USED_W'(1);
                end
            end
            ACT_ADD_REJECT: begin
                if (w_rej_full) begin
                    o_job.status = ST_FULL;
                end else begin
                    w_rej_wr   = i_fire;
                    n_rej_used = r_rej_used + USED_W'(1);
                end
            end
            ACT_CLEAR: begin
                n_acc_used = '0;
                n_rej_used = '0;
            end
            default: begin
                o_job.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_used <= '0;
            r_rej_used <= '0;
        end else if (i_fire) begin
            r_acc_used <= n_acc_used;
            r_rej_used <= n_rej_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_wr) begin
            r_acc_net[r_acc_used[IDX_W-1:0]]  <= i_entry_net;
            r_acc_mask[r_acc_used[IDX_W-1:0]] <= i_entry_mask;
        end
        if (w_rej_wr) begin
            r_rej_net[r_rej_used[IDX_W-1:0]]  <= i_entry_net;
            r_rej_mask[r_rej_used[IDX_W-1:0]] <= i_entry_mask;
        end
    end

endmodule

>>> rtl/raf_queue.sv
module raf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  raf_pkg::t_job  i_data,
    output logic           o_full,
    output logic           o_valid,
    output raf_pkg::t_job  o_data,
    input  logic           i_pop
);
    import raf_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push, w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push)
                r_wr_ptr <= bump(r_wr_ptr);
            if (w_pop)
                r_rd_ptr <= bump(r_rd_ptr);
            if (w_push && !w_pop)
                r_count <= r_count + QCNT_W'(1);
            else if (w_pop && !w_push)
                r_count <= r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push)
            r_mem[r_wr_ptr] <= i_data;
    end

endmodule

>>> rtl/raf_back.sv
module raf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  raf_pkg::t_job         i_job,
    output logic                  o_pop,
    input  logic [15:0]           i_rate_limit,
    input  logic [23:0]           i_win_len,
    output logic                  o_valid,
    output raf_pkg::t_status      o_status,
    input  logic                  i_ready
);
    import raf_pkg::*;

    logic [31:0]      r_win_start, n_win_start;
    logic [CNT_W-1:0] r_win_count, n_win_count;
    logic             r_valid;
    t_status          r_status, n_status;
    logic [32:0]      w_diff;
    logic             w_restart;
    logic [CNT_W-1:0] w_cap, w_base;

    assign o_pop    = i_job_valid && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_status = r_status;

    assign w_diff    = {1'b0, i_job.now_sec} - {1'b0, r_win_start};
    assign w_restart = $signed(w_diff) > $signed({9'b0, i_win_len});
    assign w_cap     = {1'b0, i_rate_limit} + CNT_W'(1);
    assign w_base    = w_restart ? '0 : r_win_count;

    always_comb begin
        n_win_start = r_win_start;
        n_win_count = r_win_count;
        n_status    = i_job.status;
        if (i_job.needs_rate) begin
            if (w_restart)
                n_win_start = i_job.now_sec;
            n_win_count = (w_base < w_cap) ? w_base + CNT_W'(1) : w_cap;
            n_status    = (n_win_count <= {1'b0, i_rate_limit}) ? ST_OK : ST_RATE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= '0;
            r_win_count <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_win_start <= n_win_start;
                r_win_count <= n_win_count;
                r_valid     <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_status <= n_status;
    end

endmodule

>>> rtl/request_admission_filter_unit.sv
// Request admission filter.
// Input stream (i_s_*): one beat per request or list action. tuser carries the
// action (check, append accept entry, append reject entry, clear lists);
// tdata carries host, timeout_us, now_sec, entry_net and entry_mask.
// Output stream (o_m_*): one beat per input beat, in order, carrying a 3-bit
// status in tdata.
// Configuration: i_cfg_we with i_cfg_idx selects the timeout limit, the rate
// limit or the window length; write only while no beat is in flight.
// A beat accepted is written into the queue; the back end then registers its
// status in the output register. Throughput: one beat per cycle while the
// receiver keeps up, set by the single rate-window update in the back end.
// A four-entry queue sits between the list check and the rate limiter, so
// o_s_tready stays high through short receiver stalls and drops only once
// the queue is full; the output beat holds until taken.
// Reset (synchronous, active low) empties both lists and the queue, restarts
// the rate window at time zero and loads the configuration defaults.
module request_admission_filter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // host, timeout_us, now_sec, entry_net, entry_mask
    input  logic [raf_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // action
    input  logic [raf_pkg::IN_USER_W-1:0]   i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status, zero padding
    output logic [raf_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [raf_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import raf_pkg::*;

    logic [31:0] r_max_timeout;
    logic [15:0] r_rate_limit;
    logic [23:0] r_win_len;
    logic        w_fire, w_full, w_q_valid, w_pop;
    t_job        w_front_job, w_q_job;
    t_status     w_status;

    assign o_s_tready = !w_full;
    assign w_fire     = i_s_tvalid && o_s_tready;
    assign o_m_tdata  = {(OUT_DATA_W - 3)'(0), w_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_timeout <= MAX_TIMEOUT_RST;
            r_rate_limit  <= RATE_LIMIT_RST;
            r_win_len     <= WIN_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_TIMEOUT: r_max_timeout <= i_cfg_wdata[31:0];
                CFG_RATE_LIMIT:  r_rate_limit  <= i_cfg_wdata[15:0];
                CFG_WIN_LEN:     r_win_len     <= i_cfg_wdata[23:0];
                default:         r_max_timeout <= r_max_timeout;
            endcase
        end
    end

    raf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_action      (t_action'(i_s_tuser)),
        .i_host        (i_s_tdata[31:0]),
        .i_timeout_us  (i_s_tdata[63:32]),
        .i_now_sec     (i_s_tdata[95:64]),
        .i_entry_net   (i_s_tdata[127:96]),
        .i_entry_mask  (i_s_tdata[159:128]),
        .i_max_timeout (r_max_timeout),
        .o_job         (w_front_job)
    );

    raf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire),
        .i_data  (w_front_job),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_job),
        .i_pop   (w_pop)
    );

    raf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_q_valid),
        .i_job        (w_q_job),
        .o_pop        (w_pop),
        .i_rate_limit (r_rate_limit),
        .i_win_len    (r_win_len),
        .o_valid      (o_m_tvalid),
        .o_status     (w_status),
        .i_ready      (i_m_tready)
    );

`ifndef SYNTH
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] <= 3'd4))
        else $error("status code out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("back end took an item from an empty queue");

    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

>>> bench/admission_checker.sv
`timescale 1ns / 100ps

module admission_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // host, timeout_us, now_sec, entry_net, entry_mask
    input  logic [raf_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // action
    input  logic [raf_pkg::IN_USER_W-1:0]   i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // status, zero padding
    input  logic [raf_pkg::OUT_DATA_W-1:0]  i_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [raf_pkg::CFG_W-1:0]       i_cfg_wdata,
    output int                              o_fail_cnt,
    output int                              o_pending
);
    import raf_pkg::*;

    logic [31:0] max_tmo;
    logic [15:0] rate_lim;
    logic [23:0] rate_per;

    logic [31:0] acc_net  [LIST_DEPTH];
    logic [31:0] acc_mask [LIST_DEPTH];
    logic [31:0] rej_net  [LIST_DEPTH];
    logic [31:0] rej_mask [LIST_DEPTH];
    int          acc_used;
    int          rej_used;
    logic [31:0] win_start;
    int          win_cnt;

    t_status     status_due[$];
    t_status     want;
    int          fail_cnt = 0;
    int          pend_cnt = 0;

    assign o_fail_cnt = fail_cnt;
    assign o_pending  = pend_cnt;

    task automatic report_mismatch(input string msg);
        $display("%0t: status beat: %s", $realtime, msg);
        fail_cnt++;
    endtask

    function automatic bit list_hit(input bit from_accept, input logic [31:0] host);
        int used;
        used = from_accept ? acc_used : rej_used;
        for (int k = 0; k < used; k++) begin
            if (from_accept) begin
                if ((host & acc_mask[k]) == acc_net[k]) return 1'b1;
            end else begin
                if ((host & rej_mask[k]) == rej_net[k]) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit window_admit(input logic [31:0] now);
        longint elapsed;
        int     cap;
        elapsed = longint'({32'd0, now}) - longint'({32'd0, win_start});
        cap     = int'(rate_lim) + 1;
        if (elapsed > longint'(rate_per)) begin
            win_cnt   = 0;
            win_start = now;
        end
        if (win_cnt < cap) win_cnt = win_cnt + 1;
        else win_cnt = cap;
        return win_cnt <= int'(rate_lim);
    endfunction

    function automatic t_status admit_status(input t_action act,
                                             input logic [IN_DATA_W-1:0] d);
        logic [31:0] host, tmo, now, net, mask;
        host = d[31:0];
        tmo  = d[63:32];
        now  = d[95:64];
        net  = d[127:96];
        mask = d[159:128];
        case (act)
            ACT_CHECK: begin
                if (tmo > max_tmo) return ST_TIMEOUT;
                if (acc_used != 0 && !list_hit(1'b1, host)) return ST_DENIED;
                if (list_hit(1'b0, host)) return ST_DENIED;
                return window_admit(now) ? ST_OK : ST_RATE;
            end
            ACT_ADD_ACCEPT: begin
                if (acc_used >= LIST_DEPTH) return ST_FULL;
                acc_net[acc_used]  = net;
                acc_mask[acc_used] = mask;
                acc_used++;
                return ST_OK;
            end
            ACT_ADD_REJECT: begin
                if (rej_used >= LIST_DEPTH) return ST_FULL;
                rej_net[rej_used]  = net;
                rej_mask[rej_used] = mask;
                rej_used++;
                return ST_OK;
            end
            default: begin
                acc_used = 0;
                rej_used = 0;
                return ST_OK;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_tmo   = MAX_TIMEOUT_RST;
            rate_lim  = RATE_LIMIT_RST;
            rate_per  = WIN_LEN_RST;
            acc_used  = 0;
            rej_used  = 0;
            win_start = '0;
            win_cnt   = 0;
            status_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (status_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected, got %0d", i_m_tdata[2:0]));
                end else begin
                    want = status_due.pop_front();
                    if (i_m_tdata[2:0] !== want)
                        report_mismatch($sformatf("got %0d, want %0d (%s)",
                                                  i_m_tdata[2:0], want, want.name()));
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MAX_TIMEOUT: max_tmo  = i_cfg_wdata[31:0];
                    CFG_RATE_LIMIT:  rate_lim = i_cfg_wdata[15:0];
                    CFG_WIN_LEN:     rate_per = i_cfg_wdata[23:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                status_due.push_back(admit_status(t_action'(i_s_tuser), i_s_tdata));
        end
        pend_cnt = status_due.size();
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import raf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [31:0] net;
        logic [31:0] mask;
    } t_rule;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata;
    logic [IN_USER_W-1:0]   i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic                   i_cfg_we;
    logic [1:0]             i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_wdata;

    int          fail_cnt;
    int          pending;
    int          cycle_cnt = 0;
    bit          quiet = 1'b0;
    logic [31:0] cur_max_tmo = MAX_TIMEOUT_RST;
    logic [31:0] sec_now = '0;
    t_rule       known_rules[$];

    request_admission_filter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    admission_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("request_admission_filter_unit: mismatch");
            $finish;
        end
    end

    initial begin : status_sink
        int hold;
        bit took;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                i_m_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do begin
                @(negedge i_clk);
                took = o_m_tvalid;
                @(posedge i_clk);
            end while (!took);
        end
    end

    task automatic send_beat(input t_action act, input logic [31:0] host,
                             input logic [31:0] tmo, input logic [31:0] now,
                             input logic [31:0] net, input logic [31:0] mask);
        int gap;
        bit took;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {mask, net, now, tmo, host};
        do begin
            @(negedge i_clk);
            took = o_s_tready;
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic check_req(input logic [31:0] host, input logic [31:0] tmo,
                             input logic [31:0] now);
        send_beat(ACT_CHECK, host, tmo, now, $urandom, $urandom);
    endtask

    task automatic add_rule(input t_action act, input logic [31:0] net,
                            input logic [31:0] mask);
        send_beat(act, $urandom, $urandom, $urandom, net, mask);
        if (known_rules.size() == 32) void'(known_rules.pop_front());
        known_rules.push_back('{net: net, mask: mask});
    endtask

    // hold until every status beat is back, then let the pipe settle
    task automatic drain(input int settle);
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [31:0] max_tmo, input logic [15:0] lim,
                             input logic [23:0] per);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_MAX_TIMEOUT;
        i_cfg_wdata <= max_tmo;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_RATE_LIMIT;
        i_cfg_wdata <= {16'd0, lim};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_WIN_LEN;
        i_cfg_wdata <= {8'd0, per};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_max_tmo = max_tmo;
    endtask

    function automatic logic [31:0] prefix_mask(input int len);
        return (len == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    task automatic random_run(input int n);
        int          mood;
        int          r;
        int          pick;
        t_action     act;
        t_rule       rule;
        logic [31:0] host, tmo, mask;
        mood = 0;
        for (int i = 0; i < n; i++) begin
            if (i % 32 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
                mood  = $urandom_range(0, 2);
            end
            r = $urandom_range(0, 99);
            case (mood)
                0:       act = (r < 12) ? ACT_ADD_ACCEPT : (r < 24) ? ACT_ADD_REJECT :
                               (r >= 96) ? ACT_CLEAR : ACT_CHECK;
                1:       act = (r < 40) ? ACT_ADD_ACCEPT : (r < 80) ? ACT_ADD_REJECT :
                               ACT_CHECK;
                default: act = (r < 4) ? ACT_ADD_ACCEPT : (r < 8) ? ACT_ADD_REJECT :
                               (r >= 98) ? ACT_CLEAR : ACT_CHECK;
            endcase
            case (act)
                ACT_CHECK: begin
                    if (known_rules.size() > 0 && $urandom_range(0, 9) < 6) begin
                        rule = known_rules[$urandom_range(0, known_rules.size() - 1)];
                        host = rule.net | ($urandom & ~rule.mask);
                    end else begin
                        host = $urandom;
                    end
                    case ($urandom_range(0, 9))
                        0, 1:    tmo = $urandom;
                        2:       tmo = cur_max_tmo;
                        3:       tmo = cur_max_tmo + 32'd1;
                        default: tmo = $urandom_range(0, cur_max_tmo);
                    endcase
                    pick = $urandom_range(0, 99);
                    if (pick < 3) sec_now = $urandom;
                    else if (pick < 6) sec_now = sec_now - $urandom_range(1, 100);
                    else sec_now = sec_now + $urandom_range(0, 2);
                    check_req(host, tmo, sec_now);
                end
                ACT_CLEAR: send_beat(ACT_CLEAR, $urandom, $urandom, $urandom,
                                     $urandom, $urandom);
                default: begin
                    if ($urandom_range(0, 99) < 15) begin
                        add_rule(act, $urandom, $urandom);
                    end else begin
                        mask = (act == ACT_ADD_ACCEPT) ? prefix_mask($urandom_range(0, 32))
                                                       : prefix_mask($urandom_range(16, 32));
                        add_rule(act, $urandom & mask, mask);
                    end
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= ACT_CHECK;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_MAX_TIMEOUT;
        i_cfg_wdata <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        check_req(32'h0000_0000, 32'd0, 32'd0);
        check_req(32'hFFFF_FFFF, MAX_TIMEOUT_RST, 32'd10);
        check_req(32'h1234_5678, MAX_TIMEOUT_RST + 32'd1, 32'd10);
        check_req(32'h1234_5678, 32'hFFFF_FFFF, 32'd10);
        add_rule(ACT_ADD_ACCEPT, 32'h0A00_0000, 32'hFF00_0000);
        check_req(32'h0A12_3456, 32'd5, 32'd11);
        check_req(32'h0B00_0000, 32'd5, 32'd11);
        add_rule(ACT_ADD_REJECT, 32'h0A12_0000, 32'hFFFF_0000);
        check_req(32'h0A12_FFFF, 32'd5, 32'd12);
        // window restart, then a time before the window start
        check_req(32'h0A00_0001, 32'd5, 32'd100);
        check_req(32'h0A00_0001, 32'd5, 32'd0);
        check_req(32'h0A00_0001, 32'd5, 32'hFFFF_FFFF);
        check_req(32'h0A00_0001, 32'd5, 32'h7FFF_FFFF);
        send_beat(ACT_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        check_req(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        add_rule(ACT_ADD_ACCEPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        check_req(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        check_req(32'h0000_0000, 32'd0, 32'hFFFF_FFFF);
        add_rule(ACT_ADD_REJECT, 32'h0000_0000, 32'h0000_0000);
        check_req(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_beat(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain(4);

        load_regs(32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF);
        random_run(95);
        drain(4);
        load_regs(32'd0, 16'd1, 24'd1);
        random_run(95);
        drain(4);
        load_regs($urandom, 16'($urandom_range(1, 8)), 24'($urandom_range(1, 10)));
        random_run(95);
        drain(4);
        load_regs(32'd1000000, 16'd3, 24'd5);
        random_run(95);
        drain(8);
        @(negedge i_clk);

        if (fail_cnt == 0 && pending == 0) begin
            $display("request_admission_filter_unit: match");
        end else begin
            $display("request_admission_filter_unit: mismatch");
        end
        $finish;
    end

endmodule
